FILE: rtl/core/rqwp_pkg.sv
package rqwp_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int OFFSET_W   = 8;
  localparam int COUNT_W    = 9;
  localparam int USER_W     = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD_W  = OUT_DATA_W - SAMPLE_W - 1 - COUNT_W;

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_PEEK = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

FILE: rtl/core/rqwp_store.sv
module rqwp_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [rqwp_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [rqwp_pkg::SAMPLE_W-1:0] rd_data
);
  import rqwp_pkg::*;

  logic [SAMPLE_W-1:0] mem_r [DEPTH];
  logic [SAMPLE_W-1:0] q_r;
  logic [DEPTH-1:0]    vld_r;
  logic                q_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem_r[rd_addr];
    end
  end

  // A slot that has not been written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = q_vld_r ? q_r : '0;

endmodule

FILE: rtl/core/ring_queue_word_peek.sv
// Circular queue of signed 32-bit samples with a peek back from the newest push.
// Input channel in_*: in_tuser carries the operation (push, pop, peek), in_tdata
// the sample to push and the peek offset. Every input beat gives exactly one
// result beat on out_*: the popped or peeked sample, a status code in out_tuser,
// the non-empty flag and the fill count after the operation.
// The block takes one beat per cycle while in_tready is high. A result is held
// first in the stage behind the output, where the sample memory is read at the
// accepting edge, and then in the output register. Pointer and count updates happen
// at acceptance, so the next operation already sees them.
// Reset clears the pointers and the count, and per-slot valid flip-flops make
// every slot read as zero until it is first written; no clearing pass is run.
// When the receiver stalls, one finished result waits in the output register
// and one more in the stage behind it; after that in_tready drops until
// out_tready returns.
module ring_queue_word_peek #(
  parameter int DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] push_value, [39:32] back_offset
  input  logic [rqwp_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] mode
  input  logic [rqwp_pkg::USER_W-1:0]     in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] read_value, [32] not_empty, [41:33] fill_count, [47:42] zero
  output logic [rqwp_pkg::OUT_DATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [rqwp_pkg::USER_W-1:0]     out_tuser
);
  import rqwp_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [AW-1:0] newest_r, newest_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic                s1_valid_r;
  logic                s1_rd_r;
  status_t             s1_status_r;
  logic [CW-1:0]       s1_count_r;
  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  status_t             out_status_r;

  logic                in_acc;
  logic                advance;
  mode_t               mode;
  logic [SAMPLE_W-1:0] push_value;
  logic [OFFSET_W-1:0] back_offset;
  logic [16:0]         rem;
  logic [AW-1:0]       back_mod;
  logic [AW-1:0]       peek_slot;
  logic                wr_en, rd_en, is_rd;
  logic [AW-1:0]       rd_addr;
  status_t             status;
  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] rd_val;

  assign mode        = mode_t'(in_tuser[1:0]);
  assign push_value  = in_tdata[SAMPLE_W-1:0];
  assign back_offset = in_tdata[SAMPLE_W+OFFSET_W-1:SAMPLE_W];

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  // Offset modulo DEPTH by restoring subtraction of DEPTH scaled by powers of two.
  always_comb begin
    rem = 17'(back_offset);
    for (int k = 7; k >= 0; k--) begin
      if (rem >= (17'(DEPTH) << k)) begin
        rem = rem - (17'(DEPTH) << k);
      end
    end
    back_mod = rem[AW-1:0];
    if (newest_r >= back_mod) begin
      peek_slot = newest_r - back_mod;
    end else begin
      peek_slot = AW'(PW'(newest_r) + PW'(DEPTH) - PW'(back_mod));
    end
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    newest_nxt = newest_r;
    count_nxt  = count_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    is_rd      = 1'b0;
    rd_addr    = head_r;
    status     = ST_OK;
    if (in_acc) begin
      unique case (mode)
        MODE_PUSH: begin
          if (count_r == CW'(DEPTH)) begin
            status = ST_FULL;
          end else begin
            wr_en      = 1'b1;
            newest_nxt = tail_r;
            tail_nxt   = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
            count_nxt  = count_r + 1'b1;
          end
        end
        MODE_POP: begin
          if (count_r == '0) begin
            status = ST_EMPTY;
          end else begin
            rd_en     = 1'b1;
            is_rd     = 1'b1;
            rd_addr   = head_r;
            head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
        MODE_PEEK: begin
          rd_en   = 1'b1;
          is_rd   = 1'b1;
          rd_addr = peek_slot;
        end
        default: begin
        end
      endcase
    end
  end

  rqwp_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      newest_r   <= '0;
      count_r    <= '0;
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      newest_r <= newest_nxt;
      count_r  <= count_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // The read data stays put while the stage waits, since a read only starts
  // when a new beat is accepted.
  assign rd_val = s1_rd_r ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_rd_r     <= is_rd;
      s1_status_r <= status;
      s1_count_r  <= count_nxt;
    end
    if (advance && s1_valid_r) begin
      out_data_r   <= {OUT_PAD_W'(0), COUNT_W'(s1_count_r), (s1_count_r != '0), rd_val};
      out_status_r <= s1_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  logic [PW-1:0] ptr_sum;
  assign ptr_sum = PW'(head_r) + PW'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (ptr_sum >= PW'(DEPTH)) ? (tail_r == AW'(ptr_sum - PW'(DEPTH)))
                            : (tail_r == AW'(ptr_sum)))
    else $error("tail pointer out of step with head and count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_FULL) |->
      out_data_r[SAMPLE_W+COUNT_W:SAMPLE_W+1] == COUNT_W'(DEPTH))
    else $error("full status without a full count");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_EMPTY) |->
      (out_data_r[SAMPLE_W+COUNT_W:SAMPLE_W] == '0) && (out_data_r[SAMPLE_W-1:0] == '0))
    else $error("empty status with a nonzero count or value");

  a_not_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      out_data_r[SAMPLE_W] == (out_data_r[SAMPLE_W+COUNT_W:SAMPLE_W+1] != '0))
    else $error("non-empty flag disagrees with fill count");

endmodule
